// ----- rtl/lbc_pkg.sv -----
// Shared widths, types and the edge-test helper for the line clipper.
// No dependencies; every rtl module imports this package.
`default_nettype none
package lbc_pkg;

  localparam int CW = 12;                 // coordinate width
  localparam int FRAC = 20;               // fraction bits of u
  localparam int QW = CW + FRAC;          // quotient width
  localparam int RW = QW + 2;             // signed ratio width
  localparam int UW = FRAC + 1;           // u in [0, 1]
  localparam int PW = UW + CW + 2;        // u * delta product width
  localparam int NUM_EDGES = 4;
  localparam int DIV_STEP = 4;            // quotient bits per divider stage
  localparam int DIV_STAGES = (QW + DIV_STEP - 1) / DIV_STEP;
  localparam int PADW = DIV_STAGES * DIV_STEP;
  localparam int LATENCY = DIV_STAGES + 5;

  localparam logic [UW-1:0] U_ONE = UW'(1) << FRAC;

  localparam logic [CW-1:0] LEFT_RST = CW'(300);
  localparam logic [CW-1:0] RIGHT_RST = CW'(700);
  localparam logic [CW-1:0] LOW_RST = CW'(100);
  localparam logic [CW-1:0] HIGH_RST = CW'(700);

  localparam logic [1:0] REG_LEFT = 2'd0;
  localparam logic [1:0] REG_RIGHT = 2'd1;
  localparam logic [1:0] REG_LOW = 2'd2;
  localparam logic [1:0] REG_HIGH = 2'd3;

  typedef struct packed {
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
  } seg_t;

  typedef struct packed {
    logic p_zero;
    logic p_neg;
    logic q_neg;
  } edge_t;

  typedef struct packed {
    logic ok;
    logic [UW-1:0] u_in;
    logic [UW-1:0] u_out;
  } edge_res_t;

  function automatic logic signed [RW-1:0] make_ratio(edge_t ef, logic [QW-1:0] mr);
    logic signed [RW-1:0] r;
    r = $signed({2'b00, mr});
    if (ef.p_neg ^ ef.q_neg) r = -r;
    return r;
  endfunction

  function automatic edge_res_t edge_step(edge_t ef, logic signed [RW-1:0] r,
                                          logic [UW-1:0] u_in, logic [UW-1:0] u_out);
    edge_res_t res;
    logic signed [RW-1:0] si;
    logic signed [RW-1:0] so;
    si = $signed({{(RW-UW){1'b0}}, u_in});
    so = $signed({{(RW-UW){1'b0}}, u_out});
    res.ok = 1'b1;
    res.u_in = u_in;
    res.u_out = u_out;
    if (ef.p_zero) begin
      res.ok = !ef.q_neg;
    end else if (ef.p_neg) begin
      if (r > so) res.ok = 1'b0;
      else if (r > si) res.u_in = r[UW-1:0];
    end else begin
      if (r < si) res.ok = 1'b0;
      else if (r < so) res.u_out = r[UW-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/liang_barsky_line_clip_core.sv -----
// Liang-Barsky segment clipper against a window held in four registers.
// Depends on lbc_pkg, lbc_div, lbc_clip, lbc_move.
//
// Usage:
//  - Drive start_x/start_y/end_x/end_y and raise start; the item is taken at
//    every edge where start is high and busy is low. busy is high only in reset.
//  - One segment per clock, back to back, while busy is low. Each item's result
//    passes through the input stage, the pipelined divider (4 quotient bits
//    per stage), the left/right then low-y/high-y edge tests, and the product and sum stages.
//  - done is high for one cycle with visible, the four clipped coordinates,
//    start_moved and end_moved. The receiver cannot stall; results are
//    presented once and are never held.
//  - Rejected segments come back unchanged with visible low.
//  - Window registers are written through cfg_write/cfg_index/cfg_data; write
//    them only while no item is in flight.
//  - Reset (rst, synchronous) drops all items in flight and loads the window
//    300..700 in x and 100..700 in y.
`default_nettype none
module liang_barsky_line_clip_core
  import lbc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [CW-1:0] start_x,
  input  wire logic [CW-1:0] start_y,
  input  wire logic [CW-1:0] end_x,
  input  wire logic [CW-1:0] end_y,
  input  wire logic          cfg_write,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [CW-1:0] cfg_data,
  output logic               done,
  output logic               visible,
  output logic      [CW-1:0] out_start_x,
  output logic      [CW-1:0] out_start_y,
  output logic      [CW-1:0] out_end_x,
  output logic      [CW-1:0] out_end_y,
  output logic               start_moved,
  output logic               end_moved
);

  logic [CW-1:0] window_left, window_right, window_low_y, window_high_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left <= LEFT_RST;
      window_right <= RIGHT_RST;
      window_low_y <= LOW_RST;
      window_high_y <= HIGH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LEFT:  window_left <= cfg_data;
        REG_RIGHT: window_right <= cfg_data;
        REG_LOW:   window_low_y <= cfg_data;
        REG_HIGH:  window_high_y <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = rst;

  // input stage
  logic valid0;
  seg_t seg0;

  always_ff @(posedge clk) begin
    if (rst) valid0 <= 1'b0;
    else valid0 <= start && !busy;
    seg0 <= '{sx: start_x, sy: start_y, ex: end_x, ey: end_y};
  end

  // p and q per edge, as sign and magnitude
  logic signed [CW:0] dx, dy;
  logic signed [CW:0] q [NUM_EDGES];
  logic [NUM_EDGES-1:0][CW-1:0] mq, mp;
  edge_t [NUM_EDGES-1:0] edges0;

  always_comb begin
    dx = $signed({1'b0, seg0.ex}) - $signed({1'b0, seg0.sx});
    dy = $signed({1'b0, seg0.ey}) - $signed({1'b0, seg0.sy});
    q[0] = $signed({1'b0, seg0.sx}) - $signed({1'b0, window_left});
    q[1] = $signed({1'b0, window_right}) - $signed({1'b0, seg0.sx});
    q[2] = $signed({1'b0, seg0.sy}) - $signed({1'b0, window_low_y});
    q[3] = $signed({1'b0, window_high_y}) - $signed({1'b0, seg0.sy});
    for (int e = 0; e < NUM_EDGES; e++) begin
      mq[e] = q[e][CW] ? CW'(-q[e]) : q[e][CW-1:0];
      edges0[e].q_neg = q[e][CW];
    end
    mp[0] = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    mp[1] = mp[0];
    mp[2] = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    mp[3] = mp[2];
    edges0[0].p_zero = (dx == '0);
    edges0[1].p_zero = (dx == '0);
    edges0[2].p_zero = (dy == '0);
    edges0[3].p_zero = (dy == '0);
    edges0[0].p_neg = !dx[CW] && (dx != '0);
    edges0[1].p_neg = dx[CW];
    edges0[2].p_neg = !dy[CW] && (dy != '0);
    edges0[3].p_neg = dy[CW];
  end

  logic [NUM_EDGES-1:0][QW-1:0] quo;

  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_div
    lbc_div u_div (
      .clk (clk),
      .mq  (mq[e]),
      .mp  (mp[e]),
      .quo (quo[e])
    );
  end

  // side data riding along with the divider
  logic                  dvalid [DIV_STAGES];
  seg_t                  dseg   [DIV_STAGES];
  edge_t [NUM_EDGES-1:0] dedges [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_STAGES; s++) dvalid[s] <= 1'b0;
    end else begin
      dvalid[0] <= valid0;
      for (int s = 1; s < DIV_STAGES; s++) dvalid[s] <= dvalid[s-1];
    end
    dseg[0] <= seg0;
    dedges[0] <= edges0;
    for (int s = 1; s < DIV_STAGES; s++) begin
      dseg[s] <= dseg[s-1];
      dedges[s] <= dedges[s-1];
    end
  end

  logic          c_valid, c_visible;
  logic [UW-1:0] c_u_in, c_u_out;
  seg_t          c_seg;

  lbc_clip u_clip (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (dvalid[DIV_STAGES-1]),
    .in_seg      (dseg[DIV_STAGES-1]),
    .in_edges    (dedges[DIV_STAGES-1]),
    .in_quo      (quo),
    .out_valid   (c_valid),
    .out_visible (c_visible),
    .out_u_in    (c_u_in),
    .out_u_out   (c_u_out),
    .out_seg     (c_seg)
  );

  seg_t o_seg;

  lbc_move u_move (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (c_valid),
    .in_visible      (c_visible),
    .in_u_in         (c_u_in),
    .in_u_out        (c_u_out),
    .in_seg          (c_seg),
    .out_valid       (done),
    .out_visible     (visible),
    .out_seg         (o_seg),
    .out_start_moved (start_moved),
    .out_end_moved   (end_moved)
  );

  assign out_start_x = o_seg.sx;
  assign out_start_y = o_seg.sy;
  assign out_end_x = o_seg.ex;
  assign out_end_y = o_seg.ey;

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching item");

  a_reject_flags: assert property (@(posedge clk) disable iff (rst)
    done && !visible |-> !start_moved && !end_moved)
    else $error("rejected item flagged as moved");

  a_start_kept: assert property (@(posedge clk) disable iff (rst)
    done && !start_moved |-> out_start_x == $past(start_x, LATENCY)
                          && out_start_y == $past(start_y, LATENCY))
    else $error("unmoved start changed");

  a_end_kept: assert property (@(posedge clk) disable iff (rst)
    done && !end_moved |-> out_end_x == $past(end_x, LATENCY)
                        && out_end_y == $past(end_y, LATENCY))
    else $error("unmoved end changed");
`endif

endmodule
`default_nettype wire

// ----- rtl/lbc_div.sv -----
// Pipelined restoring divider: (mq << FRAC) / mp, DIV_STEP quotient bits per stage.
// Depends on lbc_pkg.
`default_nettype none
module lbc_div
  import lbc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic [CW-1:0] mq,
  input  wire logic [CW-1:0] mp,
  output logic      [QW-1:0] quo
);

  logic [CW-1:0]   rem_r [DIV_STAGES];
  logic [PADW-1:0] num_r [DIV_STAGES];
  logic [CW-1:0]   div_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [CW-1:0]   rem_in;
    logic [PADW-1:0] num_in;
    logic [CW-1:0]   div_in;
    logic [CW-1:0]   rem_next;
    logic [PADW-1:0] num_next;

    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = PADW'({mq, {FRAC{1'b0}}});
      assign div_in = mp;
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign num_in = num_r[s-1];
      assign div_in = div_r[s-1];
    end

    // num shifts dividend bits out at the top and quotient bits in at the bottom
    always_comb begin
      logic [CW:0] trial;
      rem_next = rem_in;
      num_next = num_in;
      for (int k = 0; k < DIV_STEP; k++) begin
        trial = {rem_next, num_next[PADW-1]};
        num_next = num_next << 1;
        if (trial >= {1'b0, div_in}) begin
          trial = trial - {1'b0, div_in};
          num_next[0] = 1'b1;
        end
        rem_next = trial[CW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_next;
      num_r[s] <= num_next;
      div_r[s] <= div_in;
    end
  end

  assign quo = num_r[DIV_STAGES-1][QW-1:0];

endmodule
`default_nettype wire

// ----- rtl/lbc_clip.sv -----
// Edge tests: left/right in the first stage, low-y/high-y in the second.
// Depends on lbc_pkg.
`default_nettype none
module lbc_clip
  import lbc_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire seg_t                           in_seg,
  input  wire edge_t [NUM_EDGES-1:0]          in_edges,
  input  wire logic  [NUM_EDGES-1:0][QW-1:0]  in_quo,
  output logic                                out_valid,
  output logic                                out_visible,
  output logic       [UW-1:0]                 out_u_in,
  output logic       [UW-1:0]                 out_u_out,
  output seg_t                                out_seg
);

  logic                valid_a;
  logic                ok_a;
  logic [UW-1:0]       u_in_a;
  logic [UW-1:0]       u_out_a;
  seg_t                seg_a;
  edge_t [1:0]         edges_a;
  logic signed [RW-1:0] r2_a;
  logic signed [RW-1:0] r3_a;

  edge_res_t res0, res1, res2, res3;

  always_comb begin
    res0 = edge_step(in_edges[0], make_ratio(in_edges[0], in_quo[0]), '0, U_ONE);
    res1 = edge_step(in_edges[1], make_ratio(in_edges[1], in_quo[1]), res0.u_in, res0.u_out);
    res2 = edge_step(edges_a[0], r2_a, u_in_a, u_out_a);
    res3 = edge_step(edges_a[1], r3_a, res2.u_in, res2.u_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a <= in_valid;
      out_valid <= valid_a;
    end
    ok_a <= res0.ok && res1.ok;
    u_in_a <= res1.u_in;
    u_out_a <= res1.u_out;
    seg_a <= in_seg;
    edges_a <= in_edges[3:2];
    r2_a <= make_ratio(in_edges[2], in_quo[2]);
    r3_a <= make_ratio(in_edges[3], in_quo[3]);
    out_visible <= ok_a && res2.ok && res3.ok;
    out_u_in <= res3.u_in;
    out_u_out <= res3.u_out;
    out_seg <= seg_a;
  end

endmodule
`default_nettype wire

// ----- rtl/lbc_move.sv -----
// Endpoint move: start + u*delta, products registered, then sum and truncate.
// Depends on lbc_pkg.
`default_nettype none
module lbc_move
  import lbc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_visible,
  input  wire logic [UW-1:0] in_u_in,
  input  wire logic [UW-1:0] in_u_out,
  input  wire seg_t          in_seg,
  output logic               out_valid,
  output logic               out_visible,
  output seg_t               out_seg,
  output logic               out_start_moved,
  output logic               out_end_moved
);

  logic                valid_m;
  logic                visible_m;
  logic                smove_m;
  logic                emove_m;
  seg_t                seg_m;
  logic signed [PW-1:0] prod_m [4];   // start x, start y, end x, end y

  logic signed [CW:0] dx;
  logic signed [CW:0] dy;
  logic [CW-1:0] new_c [4];

  assign dx = $signed({1'b0, in_seg.ex}) - $signed({1'b0, in_seg.sx});
  assign dy = $signed({1'b0, in_seg.ey}) - $signed({1'b0, in_seg.sy});

  function automatic logic [CW-1:0] finish(logic [CW-1:0] base, logic signed [PW-1:0] prod);
    logic signed [PW:0] s;
    s = $signed({{(PW+1-QW){1'b0}}, base, {FRAC{1'b0}}}) + (PW+1)'(prod);
    return s[PW] ? '0 : s[FRAC+CW-1:FRAC];
  endfunction

  always_comb begin
    new_c[0] = finish(seg_m.sx, prod_m[0]);
    new_c[1] = finish(seg_m.sy, prod_m[1]);
    new_c[2] = finish(seg_m.sx, prod_m[2]);
    new_c[3] = finish(seg_m.sy, prod_m[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_m <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_m <= in_valid;
      out_valid <= valid_m;
    end
    visible_m <= in_visible;
    smove_m <= in_visible && (in_u_in != '0);
    emove_m <= in_visible && (in_u_out < U_ONE);
    seg_m <= in_seg;
    prod_m[0] <= PW'($signed({1'b0, in_u_in}) * dx);
    prod_m[1] <= PW'($signed({1'b0, in_u_in}) * dy);
    prod_m[2] <= PW'($signed({1'b0, in_u_out}) * dx);
    prod_m[3] <= PW'($signed({1'b0, in_u_out}) * dy);

    out_visible <= visible_m;
    out_start_moved <= smove_m;
    out_end_moved <= emove_m;
    out_seg.sx <= smove_m ? new_c[0] : seg_m.sx;
    out_seg.sy <= smove_m ? new_c[1] : seg_m.sy;
    out_seg.ex <= emove_m ? new_c[2] : seg_m.ex;
    out_seg.ey <= emove_m ? new_c[3] : seg_m.ey;
  end

endmodule
`default_nettype wire
